[hw/rtl/ffls_pkg.sv]
// Shared types, widths and constants of the flat-face Lambert shader.
package ffls_pkg;

   localparam int FRACTION_BITS = 14;

   localparam int NORM_W  = 16;
   localparam int LEVEL_W = 8;
   localparam int SUM_W   = NORM_W + 2;
   localparam int POS_W   = SUM_W - 1;
   localparam int INV_W   = 30;
   localparam logic [INV_W-1:0] INV_SQRT3 = 30'd619925131;
   localparam int PROD_W  = POS_W + INV_W;

   localparam int D_W     = FRACTION_BITS + 1;
   localparam int CLAMP_W = (POS_W > D_W) ? POS_W : D_W;
   localparam longint unsigned ONE_VAL = 64'd1 << FRACTION_BITS;
   localparam int TERM_W  = D_W + LEVEL_W;
   localparam int NY_W    = NORM_W - 1;
   localparam int HL_W    = NY_W + LEVEL_W;

   localparam int LIGHT_W = (FRACTION_BITS + 10 > 24) ? FRACTION_BITS + 10 : 24;
   localparam int Q_W     = LIGHT_W + LEVEL_W - FRACTION_BITS;
   localparam int RECIP_SHIFT = Q_W + 8;
   localparam int RECIP_W = RECIP_SHIFT - 7;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RECIP_SHIFT) + 64'd254) / 64'd255;
   localparam int R_W     = Q_W + RECIP_W;
   localparam int QT_W    = Q_W - 7;
   localparam int SAT_W   = QT_W + 1;

   localparam int IDX_W = 3;

   typedef enum logic [IDX_W-1:0] {
      REG_AMBIENT   = 3'd0,
      REG_LIGHT_ONE = 3'd1,
      REG_LIGHT_TWO = 3'd2,
      REG_HIGHLIGHT = 3'd3,
      REG_EMITTED   = 3'd4
   } reg_index_type;

   localparam logic [LEVEL_W-1:0] AMBIENT_RESET   = 8'd80;
   localparam logic [LEVEL_W-1:0] LIGHT_ONE_RESET = 8'd125;
   localparam logic [LEVEL_W-1:0] LIGHT_TWO_RESET = 8'd50;
   localparam logic [LEVEL_W-1:0] HIGHLIGHT_RESET = 8'd175;
   localparam logic [LEVEL_W-1:0] EMITTED_RESET   = 8'd70;

   typedef struct packed {
      logic [LEVEL_W-1:0] ambient;
      logic [LEVEL_W-1:0] light_one;
      logic [LEVEL_W-1:0] light_two;
      logic [LEVEL_W-1:0] highlight;
      logic [LEVEL_W-1:0] emitted;
   } cfg_type;

   typedef logic [2:0][LEVEL_W-1:0] rgb_type;

endpackage

[hw/rtl/flat_face_lambert_shader.sv]
// Top level of the flat-face Lambert shader: one shaded RGB color per face.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, normal x/y/z, reflectivity
//   rsp      out        rsp_valid/rsp_stall  shaded red, green, blue
//   csr      in         csr_valid/csr_ready  register index, 8-bit data
//
// A new request can enter every cycle in which req_stall is low;
// the depth is set by the four light-sum stages and the three scaling stages.
// Reset clears all valid bits and loads the default light levels.
// A stalled response holds the output stage; earlier stages keep moving into
// empty slots, so the request side stalls only once the pipeline is full.
module flat_face_lambert_shader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [ffls_pkg::NORM_W-1:0]  req_normal_x,
   input  logic signed [ffls_pkg::NORM_W-1:0]  req_normal_y,
   input  logic signed [ffls_pkg::NORM_W-1:0]  req_normal_z,
   input  logic [ffls_pkg::LEVEL_W-1:0]        req_refl_red,
   input  logic [ffls_pkg::LEVEL_W-1:0]        req_refl_green,
   input  logic [ffls_pkg::LEVEL_W-1:0]        req_refl_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ffls_pkg::LEVEL_W-1:0]        rsp_out_red,
   output logic [ffls_pkg::LEVEL_W-1:0]        rsp_out_green,
   output logic [ffls_pkg::LEVEL_W-1:0]        rsp_out_blue,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffls_pkg::IDX_W-1:0]          csr_index,
   input  logic [ffls_pkg::LEVEL_W-1:0]        csr_data
);

   ffls_pkg::cfg_type            cfg;
   ffls_pkg::rgb_type            req_refl;
   ffls_pkg::rgb_type            mid_refl;
   ffls_pkg::rgb_type            rsp_rgb;
   logic                         light_ready;
   logic                         mid_valid;
   logic                         mid_ready;
   logic [ffls_pkg::LIGHT_W-1:0] mid_light;
   logic                         mid_action;

   assign req_refl[0] = req_refl_red;
   assign req_refl[1] = req_refl_green;
   assign req_refl[2] = req_refl_blue;
   assign req_stall   = !light_ready;

   assign rsp_out_red   = rsp_rgb[0];
   assign rsp_out_green = rsp_rgb[1];
   assign rsp_out_blue  = rsp_rgb[2];

   ffls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ffls_light u_light (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_valid),
      .in_ready   (light_ready),
      .in_action  (req_action),
      .in_nx      (req_normal_x),
      .in_ny      (req_normal_y),
      .in_nz      (req_normal_z),
      .in_refl    (req_refl),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_light  (mid_light),
      .out_action (mid_action),
      .out_refl   (mid_refl)
   );

   ffls_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_light  (mid_light),
      .in_action (mid_action),
      .in_refl   (mid_refl),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rgb   (rsp_rgb)
   );

endmodule

[hw/rtl/ffls_csr.sv]
// Configuration registers of the shader, written through the csr port.
module ffls_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffls_pkg::IDX_W-1:0]      csr_index,
   input  logic [ffls_pkg::LEVEL_W-1:0]    csr_data,
   output ffls_pkg::cfg_type               cfg
);

   ffls_pkg::cfg_type cfg_ff;
   ffls_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ffls_pkg::reg_index_type'(csr_index))
            ffls_pkg::REG_AMBIENT:   cfg_in.ambient   = csr_data;
            ffls_pkg::REG_LIGHT_ONE: cfg_in.light_one = csr_data;
            ffls_pkg::REG_LIGHT_TWO: cfg_in.light_two = csr_data;
            ffls_pkg::REG_HIGHLIGHT: cfg_in.highlight = csr_data;
            ffls_pkg::REG_EMITTED:   cfg_in.emitted   = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ambient   <= ffls_pkg::AMBIENT_RESET;
         cfg_ff.light_one <= ffls_pkg::LIGHT_ONE_RESET;
         cfg_ff.light_two <= ffls_pkg::LIGHT_TWO_RESET;
         cfg_ff.highlight <= ffls_pkg::HIGHLIGHT_RESET;
         cfg_ff.emitted   <= ffls_pkg::EMITTED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/ffls_light.sv]
// Four-stage pipeline that forms the light sum of one face.
module ffls_light (
   input  logic                                clock,
   input  logic                                reset,
   input  ffls_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                in_action,
   input  logic signed [ffls_pkg::NORM_W-1:0]  in_nx,
   input  logic signed [ffls_pkg::NORM_W-1:0]  in_ny,
   input  logic signed [ffls_pkg::NORM_W-1:0]  in_nz,
   input  ffls_pkg::rgb_type                   in_refl,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ffls_pkg::LIGHT_W-1:0]        out_light,
   output logic                                out_action,
   output ffls_pkg::rgb_type                   out_refl
);

   localparam int SW = ffls_pkg::SUM_W;
   localparam int NW = ffls_pkg::NORM_W;

   logic en_a, en_b, en_c, en_d;
   logic va_ff, vb_ff, vc_ff, vd_ff;

   // Stage A: diagonal sums.
   logic signed [SW-1:0]           sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic                           neg_a_ff, act_a_ff;
   logic [ffls_pkg::NY_W-1:0]      ny_a_ff;
   ffls_pkg::rgb_type              refl_a_ff;
   // Stage B: projections and highlight term.
   logic [ffls_pkg::POS_W-1:0]     pos1, pos2;
   logic [ffls_pkg::PROD_W-1:0]    prod1, prod2;
   logic [ffls_pkg::POS_W-1:0]     draw1_ff, draw1_in, draw2_ff, draw2_in;
   logic [ffls_pkg::HL_W-1:0]      hl_b_ff, hl_b_in;
   logic                           neg_b_ff, act_b_ff;
   ffls_pkg::rgb_type              refl_b_ff;
   // Stage C: clamped light terms.
   logic [ffls_pkg::D_W-1:0]       d1, d2;
   logic [ffls_pkg::TERM_W-1:0]    t1_ff, t1_in, t2_ff, t2_in;
   logic [ffls_pkg::HL_W-1:0]      hl_c_ff;
   logic                           neg_c_ff, act_c_ff;
   ffls_pkg::rgb_type              refl_c_ff;
   // Stage D: light sum.
   logic [ffls_pkg::LIGHT_W-1:0]   amb_term;
   logic [ffls_pkg::LIGHT_W-1:0]   light_ff, light_in;
   logic                           act_d_ff;
   ffls_pkg::rgb_type              refl_d_ff;

   assign en_d     = !vd_ff || out_ready;
   assign en_c     = !vc_ff || en_d;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign out_valid  = vd_ff;
   assign out_light  = light_ff;
   assign out_action = act_d_ff;
   assign out_refl   = refl_d_ff;

   always_comb begin
      sum1_in = {{2{in_nx[NW-1]}}, in_nx} + {{2{in_ny[NW-1]}}, in_ny}
              + {{2{in_nz[NW-1]}}, in_nz};
      sum2_in = {{2{in_ny[NW-1]}}, in_ny} + {{2{in_nz[NW-1]}}, in_nz}
              - {{2{in_nx[NW-1]}}, in_nx};
   end

   always_comb begin
      pos1 = (!sum1_ff[SW-1] && (sum1_ff != '0)) ? sum1_ff[ffls_pkg::POS_W-1:0] : '0;
      pos2 = (!sum2_ff[SW-1] && (sum2_ff != '0)) ? sum2_ff[ffls_pkg::POS_W-1:0] : '0;
      prod1 = ffls_pkg::PROD_W'(pos1) * ffls_pkg::PROD_W'(ffls_pkg::INV_SQRT3);
      prod2 = ffls_pkg::PROD_W'(pos2) * ffls_pkg::PROD_W'(ffls_pkg::INV_SQRT3);
      draw1_in = prod1[ffls_pkg::PROD_W-1:ffls_pkg::INV_W];
      draw2_in = prod2[ffls_pkg::PROD_W-1:ffls_pkg::INV_W];
      hl_b_in = ffls_pkg::HL_W'(ny_a_ff) * ffls_pkg::HL_W'(cfg.highlight);
   end

   always_comb begin
      if (ffls_pkg::CLAMP_W'(draw1_ff) > ffls_pkg::CLAMP_W'(ffls_pkg::ONE_VAL)) begin
         d1 = ffls_pkg::D_W'(ffls_pkg::ONE_VAL);
      end else begin
         d1 = ffls_pkg::D_W'(draw1_ff);
      end
      if (ffls_pkg::CLAMP_W'(draw2_ff) > ffls_pkg::CLAMP_W'(ffls_pkg::ONE_VAL)) begin
         d2 = ffls_pkg::D_W'(ffls_pkg::ONE_VAL);
      end else begin
         d2 = ffls_pkg::D_W'(draw2_ff);
      end
      t1_in = ffls_pkg::TERM_W'(d1) * ffls_pkg::TERM_W'(cfg.light_one);
      t2_in = ffls_pkg::TERM_W'(d2) * ffls_pkg::TERM_W'(cfg.light_two);
   end

   always_comb begin
      amb_term = ffls_pkg::LIGHT_W'(cfg.ambient) << ffls_pkg::FRACTION_BITS;
      priority if (neg_c_ff) begin
         light_in = amb_term;
      end else if (act_c_ff) begin
         light_in = ffls_pkg::LIGHT_W'(hl_c_ff) + amb_term;
      end else begin
         light_in = ffls_pkg::LIGHT_W'(t1_ff) + ffls_pkg::LIGHT_W'(t2_ff) + amb_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
         if (en_d) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         sum1_ff   <= sum1_in;
         sum2_ff   <= sum2_in;
         neg_a_ff  <= in_ny[NW-1];
         act_a_ff  <= in_action;
         ny_a_ff   <= in_ny[ffls_pkg::NY_W-1:0];
         refl_a_ff <= in_refl;
      end
      if (en_b) begin
         draw1_ff  <= draw1_in;
         draw2_ff  <= draw2_in;
         hl_b_ff   <= hl_b_in;
         neg_b_ff  <= neg_a_ff;
         act_b_ff  <= act_a_ff;
         refl_b_ff <= refl_a_ff;
      end
      if (en_c) begin
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;
         hl_c_ff   <= hl_b_ff;
         neg_c_ff  <= neg_b_ff;
         act_c_ff  <= act_b_ff;
         refl_c_ff <= refl_b_ff;
      end
      if (en_d) begin
         light_ff  <= light_in;
         act_d_ff  <= act_c_ff;
         refl_d_ff <= refl_c_ff;
      end
   end

endmodule

[hw/rtl/ffls_scale.sv]
// Three-stage pipeline that scales the light sum by reflectivity per channel.
module ffls_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  ffls_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ffls_pkg::LIGHT_W-1:0]   in_light,
   input  logic                           in_action,
   input  ffls_pkg::rgb_type              in_refl,
   output logic                           out_valid,
   input  logic                           out_stall,
   output ffls_pkg::rgb_type              out_rgb
);

   localparam int PW = ffls_pkg::LIGHT_W + ffls_pkg::LEVEL_W;

   logic en_e, en_f, en_g;
   logic ve_ff, vf_ff, vg_ff;

   logic [2:0][PW-1:0]                  prod;
   logic [2:0][ffls_pkg::Q_W-1:0]       q_ff, q_in;
   logic                                act_e_ff, act_f_ff;
   logic [2:0][ffls_pkg::R_W-1:0]       r_ff, r_in;
   logic [2:0][ffls_pkg::QT_W-1:0]      quo;
   logic [2:0][ffls_pkg::SAT_W-1:0]     total;
   ffls_pkg::rgb_type                   rgb_ff, rgb_in;

   assign en_g     = !vg_ff || !out_stall;
   assign en_f     = !vf_ff || en_g;
   assign en_e     = !ve_ff || en_f;
   assign in_ready = en_e;

   assign out_valid = vg_ff;
   assign out_rgb   = rgb_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = PW'(in_light) * PW'(in_refl[k]);
         q_in[k] = prod[k][PW-1:ffls_pkg::FRACTION_BITS];
         r_in[k] = ffls_pkg::R_W'(q_ff[k]) * ffls_pkg::R_W'(ffls_pkg::RECIP_VAL);
         quo[k]  = r_ff[k][ffls_pkg::R_W-1:ffls_pkg::RECIP_SHIFT];
         if (act_f_ff) begin
            total[k] = ffls_pkg::SAT_W'(quo[k]) + ffls_pkg::SAT_W'(cfg.emitted);
         end else begin
            total[k] = ffls_pkg::SAT_W'(quo[k]);
         end
         if (total[k] > ffls_pkg::SAT_W'(255)) begin
            rgb_in[k] = 8'd255;
         end else begin
            rgb_in[k] = total[k][ffls_pkg::LEVEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else begin
         if (en_e) ve_ff <= in_valid;
         if (en_f) vf_ff <= ve_ff;
         if (en_g) vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         q_ff     <= q_in;
         act_e_ff <= in_action;
      end
      if (en_f) begin
         r_ff     <= r_in;
         act_f_ff <= act_e_ff;
      end
      if (en_g) begin
         rgb_ff <= rgb_in;
      end
   end

endmodule
